// ===== hw/rtl/crl_pkg.sv =====
// Shared types, codes and default sizes for the connection rate limiter.
// No dependencies; imported by crl_exempt and connection_rate_limiter.
`default_nettype none

package crl_pkg;

  localparam int RING_DEPTH_DEF   = 128;
  localparam int EXEMPT_DEPTH_DEF = 8;

  localparam int ADDR_W  = 32;
  localparam int TIME_W  = 32;
  localparam int SLOT_W  = 3;
  localparam int COUNT_W = 8;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic OP_CONNECT = 1'b0;
  localparam logic OP_EXEMPT  = 1'b1;

  localparam logic [1:0] VERDICT_OK   = 2'd0;
  localparam logic [1:0] VERDICT_BUSY = 2'd1;
  localparam logic [1:0] VERDICT_HOST = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOST_LIMIT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EXEMPT_COUNT = 2'd3;

  // Control from the sequencer to the exempt table.
  typedef struct packed {
    logic              wr_en;
    logic [SLOT_W-1:0] wr_index;
    logic [ADDR_W-1:0] wr_data;
    logic              start;
    logic [ADDR_W-1:0] addr;
  } crl_ex_ctl_t;

  // Lookup status back to the sequencer; hit is meaningful with done.
  typedef struct packed {
    logic done;
    logic hit;
  } crl_ex_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/connection_rate_limiter.sv =====
// Sliding-window connection rate limiter: ring of recent connects, walk sequencer.
// Depends on crl_pkg and crl_exempt. An exempt write or a zero window goes straight to
// the result; a connect first walks the live ring, one ring read a cycle, and searches
// the exempt table when the host limit is reached and the ring is not busy.
// One item in flight; the next word is taken only after its result is registered.
// Synchronous reset empties the ring (head and live count) and loads register defaults.
`default_nettype none

module connection_rate_limiter #(
  parameter int RING_DEPTH   = crl_pkg::RING_DEPTH_DEF,
  parameter int EXEMPT_DEPTH = crl_pkg::EXEMPT_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           opcode,
  input  wire logic [crl_pkg::TIME_W-1:0]     now_seconds,
  input  wire logic [crl_pkg::ADDR_W-1:0]     host_address,
  input  wire logic [crl_pkg::SLOT_W-1:0]     exempt_index,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [1:0]                          verdict,
  output logic [crl_pkg::COUNT_W-1:0]         live_count,
  output logic [crl_pkg::COUNT_W-1:0]         host_matches,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [crl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [crl_pkg::CFG_W-1:0]      cfg_data
);
  import crl_pkg::*;

  localparam int IW = $clog2(RING_DEPTH);
  localparam int LW = $clog2(RING_DEPTH + 1);
  localparam int CW = (LW > COUNT_W) ? LW : COUNT_W;
  localparam int PW = IW + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_DECIDE,
    S_EXEMPT,
    S_DONE
  } state_t;

  state_t state;

  logic [15:0]        window_seconds;
  logic [7:0]         total_limit;
  logic [7:0]         host_limit;
  logic [3:0]         exempt_count;

  logic [ADDR_W-1:0]  ring_address [RING_DEPTH];
  logic [TIME_W-1:0]  ring_expiry  [RING_DEPTH];
  logic [ADDR_W-1:0]  rd_address;
  logic [TIME_W-1:0]  rd_expiry;

  logic [IW-1:0]      ring_head;
  logic [LW-1:0]      ring_live;
  logic [IW-1:0]      rd_idx;
  logic [LW-1:0]      left;
  logic               pend;
  logic [LW-1:0]      match_cnt;
  logic [TIME_W-1:0]  now_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [1:0]         verdict_q;

  logic               in_accept;
  logic               issue;
  logic               is_busy;
  logic               need_lookup;
  logic               ring_we;
  logic [PW-1:0]      pos_sum;
  logic [IW-1:0]      wr_idx;

  crl_ex_ctl_t        ex_ctl;
  crl_ex_status_t     ex_status;

  function automatic logic [IW-1:0] ring_step(input logic [IW-1:0] i);
    return (i == IW'(RING_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign issue     = (left != '0);

  assign is_busy = (CW'(ring_live) >= CW'(total_limit)) ||
                   (CW'(ring_live) >= CW'(RING_DEPTH));
  assign need_lookup = (CW'(match_cnt) >= CW'(host_limit));

  assign ring_we = ((state == S_DECIDE) && !is_busy && !need_lookup) ||
                   ((state == S_EXEMPT) && ex_status.done && ex_status.hit);

  // append position wraps at the ring depth
  assign pos_sum = PW'(ring_head) + PW'(ring_live);
  assign wr_idx  = (pos_sum >= PW'(RING_DEPTH)) ? IW'(pos_sum - PW'(RING_DEPTH))
                                                : IW'(pos_sum);

  always_comb begin
    ex_ctl.wr_en    = in_accept && (opcode == OP_EXEMPT);
    ex_ctl.wr_index = exempt_index;
    ex_ctl.wr_data  = host_address;
    ex_ctl.start    = (state == S_DECIDE) && !is_busy && need_lookup;
    ex_ctl.addr     = addr_q;
  end

  crl_exempt #(
    .EXEMPT_DEPTH(EXEMPT_DEPTH)
  ) u_exempt (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ex_ctl),
    .exempt_count (exempt_count),
    .status       (ex_status)
  );

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_address[wr_idx] <= addr_q;
      ring_expiry[wr_idx]  <= now_q + TIME_W'(window_seconds);
    end
    rd_address <= ring_address[rd_idx];
    rd_expiry  <= ring_expiry[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_seconds <= '0;
      total_limit    <= 8'd64;
      host_limit     <= 8'd2;
      exempt_count   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WINDOW:       window_seconds <= cfg_data;
        CFG_TOTAL_LIMIT:  total_limit    <= cfg_data[7:0];
        CFG_HOST_LIMIT:   host_limit     <= cfg_data[7:0];
        CFG_EXEMPT_COUNT: exempt_count   <= cfg_data[3:0];
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      ring_head    <= '0;
      ring_live    <= '0;
      rd_idx       <= '0;
      left         <= '0;
      pend         <= 1'b0;
      match_cnt    <= '0;
      out_valid    <= 1'b0;
      verdict_q    <= VERDICT_OK;
      now_q        <= '0;
      addr_q       <= '0;
      verdict      <= VERDICT_OK;
      live_count   <= '0;
      host_matches <= '0;
    end else begin
      // the final state reloads the result register itself
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            now_q     <= now_seconds;
            addr_q    <= host_address;
            match_cnt <= '0;
            verdict_q <= VERDICT_OK;
            rd_idx    <= ring_head;
            left      <= ring_live;
            pend      <= 1'b0;
            if ((opcode == OP_EXEMPT) || (window_seconds == '0)) begin
              state <= S_DONE;
            end else begin
              state <= S_WALK;
            end
          end
        end
        S_WALK: begin
          // issue one read per cycle, check the entry read the cycle before
          pend <= issue;
          if (issue) begin
            rd_idx <= ring_step(rd_idx);
            left   <= left - 1'b1;
          end
          if (pend) begin
            if (rd_expiry < now_q) begin
              ring_live <= ring_live - 1'b1;
              ring_head <= ring_step(ring_head);
            end else if (rd_address == addr_q) begin
              match_cnt <= match_cnt + 1'b1;
            end
          end
          if (!issue && !pend) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (is_busy) begin
            verdict_q <= VERDICT_BUSY;
            state     <= S_DONE;
          end else if (need_lookup) begin
            state <= S_EXEMPT;
          end else begin
            verdict_q <= VERDICT_OK;
            ring_live <= ring_live + 1'b1;
            state     <= S_DONE;
          end
        end
        S_EXEMPT: begin
          if (ex_status.done) begin
            if (ex_status.hit) begin
              verdict_q <= VERDICT_OK;
              ring_live <= ring_live + 1'b1;
            end else begin
              verdict_q <= VERDICT_HOST;
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // hold until the result register is free
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            verdict      <= verdict_q;
            live_count   <= COUNT_W'(ring_live);
            host_matches <= COUNT_W'(match_cnt);
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_live_bounded: assert property (@(posedge clk) disable iff (rst)
    CW'(ring_live) <= CW'(RING_DEPTH))
    else $error("ring live count exceeds ring depth");

  a_append_has_room: assert property (@(posedge clk) disable iff (rst)
    ring_we |-> (CW'(ring_live) < CW'(RING_DEPTH)))
    else $error("ring append while full");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> in_stall)
    else $error("second word accepted while an item is in work");

  a_lookup_only_when_waiting: assert property (@(posedge clk) disable iff (rst)
    ex_status.done |-> (state == S_EXEMPT))
    else $error("exempt lookup finished outside its wait state");

endmodule

`default_nettype wire

// ===== hw/rtl/crl_exempt.sv =====
// Exempt host table with a one-entry-per-cycle sequential lookup.
// Depends on crl_pkg for the control and status structs.
`default_nettype none

module crl_exempt #(
  parameter int EXEMPT_DEPTH = crl_pkg::EXEMPT_DEPTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire crl_pkg::crl_ex_ctl_t   ctl,
  input  wire logic [3:0]             exempt_count,
  output crl_pkg::crl_ex_status_t     status
);
  import crl_pkg::*;

  localparam int EW = (EXEMPT_DEPTH > 1) ? $clog2(EXEMPT_DEPTH) : 1;
  localparam int NW = ($clog2(EXEMPT_DEPTH + 1) > 4) ? $clog2(EXEMPT_DEPTH + 1) : 4;

  logic [ADDR_W-1:0] table_mem [EXEMPT_DEPTH];
  logic [ADDR_W-1:0] rd_data;
  logic [NW-1:0]     k;
  logic [NW-1:0]     n;
  logic [NW-1:0]     n_clamp;
  logic              busy;
  logic              chk;
  logic              issue;
  logic              match;

  assign n_clamp = (NW'(exempt_count) > NW'(EXEMPT_DEPTH)) ? NW'(EXEMPT_DEPTH)
                                                            : NW'(exempt_count);
  assign issue = busy && (k < n);
  assign match = chk && (rd_data == ctl.addr);

  always_comb begin
    status.hit  = match;
    status.done = busy && (match || (!chk && (k >= n)));
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en && (int'(ctl.wr_index) < EXEMPT_DEPTH)) begin
      table_mem[EW'(ctl.wr_index)] <= ctl.wr_data;
    end
    rd_data <= table_mem[k[EW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      chk  <= 1'b0;
      k    <= '0;
      n    <= '0;
    end else if (ctl.start) begin
      busy <= 1'b1;
      chk  <= 1'b0;
      k    <= '0;
      n    <= n_clamp;
    end else if (busy) begin
      if (status.done) begin
        busy <= 1'b0;
        chk  <= 1'b0;
      end else begin
        // one entry read per cycle, compared the cycle after
        chk <= issue;
        if (issue) begin
          k <= k + 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== sim/connection_rate_limiter_tb.sv =====
// Self-checking bench for connection_rate_limiter: sends connect and exempt-table
// words, predicts each verdict from its own ring model, checks every result word.
// Depends on crl_pkg and the connection_rate_limiter RTL.
`timescale 1ns / 1ps

module connection_rate_limiter_tb;
  import crl_pkg::*;

  localparam int RING_SLOTS     = RING_DEPTH_DEF;
  localparam int EXEMPT_SLOTS   = EXEMPT_DEPTH_DEF;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 200;
  localparam int PRINT_CAP      = 40;
  localparam int ROUNDS         = 12;

  typedef struct {
    logic              op;
    logic [TIME_W-1:0] now;
    logic [ADDR_W-1:0] addr;
    logic [SLOT_W-1:0] slot;
  } conn_word_t;

  typedef struct {
    logic [1:0]         verdict;
    logic [COUNT_W-1:0] live;
    logic [COUNT_W-1:0] hits;
  } ruling_t;

  logic clk;
  logic rst = 1'b1;

  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 opcode = OP_CONNECT;
  logic [TIME_W-1:0]    now_seconds = '0;
  logic [ADDR_W-1:0]    host_address = '0;
  logic [SLOT_W-1:0]    exempt_index = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           verdict;
  logic [COUNT_W-1:0]   live_count;
  logic [COUNT_W-1:0]   host_matches;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_WINDOW;
  logic [CFG_W-1:0]     cfg_data = '0;

  // Predicted limiter state
  logic [15:0]       cfg_window = 16'd0;
  logic [7:0]        cfg_total_limit = 8'd64;
  logic [7:0]        cfg_host_limit = 8'd2;
  logic [3:0]        cfg_exempt_count = 4'd0;
  logic [ADDR_W-1:0] ring_addr [RING_SLOTS];
  logic [TIME_W-1:0] ring_expiry [RING_SLOTS];
  int                ring_head = 0;
  int                ring_live = 0;
  logic [ADDR_W-1:0] exempt_tbl [EXEMPT_SLOTS];

  conn_word_t word_q[$];
  ruling_t    ruling_q[$];

  int  sender_idle_pct = 30;
  int  receiver_idle_pct = 86;
  int  hold_requests = 0;
  int  hold_seen = 0;
  int  hold_left = 0;
  bit  in_taken = 1'b0;
  int  mismatches = 0;
  int  quiet_cycles = 0;
  int  words_sent = 0;
  int  connects_sent = 0;
  int  results_checked = 0;
  int  ok_count = 0;
  int  busy_count = 0;
  int  host_count = 0;

  connection_rate_limiter u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .now_seconds  (now_seconds),
    .host_address (host_address),
    .exempt_index (exempt_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .verdict      (verdict),
    .live_count   (live_count),
    .host_matches (host_matches),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  // Walk the live ring, retire expired entries from the head, then rule on the connect.
  function automatic ruling_t judge_word(input conn_word_t w);
    ruling_t r;
    int      idx;
    int      left;
    int      n;
    int      pos;
    bit      exempt_hit;
    r.verdict = VERDICT_OK;
    r.hits = '0;
    if (w.op == OP_EXEMPT) begin
      exempt_tbl[w.slot] = w.addr;
    end else if (cfg_window != 16'd0) begin
      idx = ring_head;
      left = ring_live;
      while (left > 0) begin
        left--;
        // an expired entry always retires the head, wherever the walk is
        if (ring_expiry[idx] < w.now) begin
          ring_live--;
          ring_head = (ring_head + 1) % RING_SLOTS;
        end else if (ring_addr[idx] == w.addr) begin
          r.hits++;
        end
        idx = (idx + 1) % RING_SLOTS;
      end
      n = (cfg_exempt_count > EXEMPT_SLOTS) ? EXEMPT_SLOTS : cfg_exempt_count;
      exempt_hit = 1'b0;
      for (int k = 0; k < n; k++) begin
        if (exempt_tbl[k] == w.addr) exempt_hit = 1'b1;
      end
      if (ring_live >= cfg_total_limit || ring_live >= RING_SLOTS) begin
        r.verdict = VERDICT_BUSY;
      end else if (r.hits >= cfg_host_limit && !exempt_hit) begin
        r.verdict = VERDICT_HOST;
      end else begin
        pos = (ring_head + ring_live) % RING_SLOTS;
        ring_addr[pos] = w.addr;
        ring_expiry[pos] = w.now + {16'd0, cfg_window};
        ring_live++;
      end
    end
    r.live = ring_live[COUNT_W-1:0];
    return r;
  endfunction

  // Sender: hold a stalled word, otherwise offer the next one or idle.
  always @(negedge clk) begin : drive_words
    conn_word_t w;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      in_valid <= 1'b1;
    end else if (word_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
      w = word_q.pop_front();
      in_valid     <= 1'b1;
      opcode       <= w.op;
      now_seconds  <= w.now;
      host_address <= w.addr;
      exempt_index <= w.slot;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: random stalls, plus a long hold-off when asked for one.
  always @(negedge clk) begin : stall_results
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_idle_pct);
    end
  end

  always @(posedge clk) begin : watch_ports
    conn_word_t w;
    ruling_t    want;
    in_taken = !rst && in_valid && !in_stall;
    if (in_taken) begin
      w.op = opcode;
      w.now = now_seconds;
      w.addr = host_address;
      w.slot = exempt_index;
      want = judge_word(w);
      ruling_q.push_back(want);
      words_sent++;
      if (w.op == OP_CONNECT) connects_sent++;
      case (want.verdict)
        VERDICT_BUSY: busy_count++;
        VERDICT_HOST: host_count++;
        default:      ok_count++;
      endcase
    end
    if (!rst && out_valid && !out_stall) begin
      if (ruling_q.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        want = ruling_q.pop_front();
        results_checked++;
        if (verdict !== want.verdict)
          report_mismatch($sformatf("verdict %0d, expected %0d", verdict, want.verdict));
        if (live_count !== want.live)
          report_mismatch($sformatf("live_count %0d, expected %0d", live_count, want.live));
        if (host_matches !== want.hits)
          report_mismatch($sformatf("host_matches %0d, expected %0d",
                                    host_matches, want.hits));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_WINDOW:       cfg_window = data;
      CFG_TOTAL_LIMIT:  cfg_total_limit = data[7:0];
      CFG_HOST_LIMIT:   cfg_host_limit = data[7:0];
      CFG_EXEMPT_COUNT: cfg_exempt_count = data[3:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_settings(input logic [15:0] win, input logic [7:0] tot,
                                input logic [7:0] hst, input logic [3:0] exc);
    write_reg(CFG_WINDOW, win);
    write_reg(CFG_TOTAL_LIMIT, {8'd0, tot});
    write_reg(CFG_HOST_LIMIT, {8'd0, hst});
    write_reg(CFG_EXEMPT_COUNT, {12'd0, exc});
  endtask

  task automatic queue_connect(input logic [TIME_W-1:0] now, input logic [ADDR_W-1:0] addr);
    conn_word_t w;
    w.op = OP_CONNECT;
    w.now = now;
    w.addr = addr;
    w.slot = SLOT_W'($urandom_range(EXEMPT_SLOTS - 1));
    word_q.push_back(w);
  endtask

  task automatic queue_exempt(input logic [SLOT_W-1:0] slot, input logic [ADDR_W-1:0] addr);
    conn_word_t w;
    w.op = OP_EXEMPT;
    w.now = $urandom;
    w.addr = addr;
    w.slot = slot;
    word_q.push_back(w);
  endtask

  // Wait until every word is sent and every result has come back.
  task automatic wait_idle();
    do begin
      @(posedge clk);
      #1;
    end while (word_q.size() != 0 || in_valid || ruling_q.size() != 0);
  endtask

  initial begin : run_test
    int                n_items;
    int                pick;
    int                step_max;
    logic [15:0]       win;
    logic [7:0]        tot;
    logic [7:0]        hst;
    logic [3:0]        exc;
    logic [TIME_W-1:0] clock_now;
    logic [ADDR_W-1:0] host_pool [4];
    logic [ADDR_W-1:0] addr;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Window zero after reset: limiting off, then fill the whole exempt table.
    queue_connect(32'd0, 32'hFFFF_FFFF);
    queue_exempt(3'd0, 32'h0A00_0001);
    queue_exempt(3'd1, 32'h0000_0000);
    queue_exempt(3'd2, 32'hFFFF_FFFF);
    for (int s = 3; s < EXEMPT_SLOTS; s++) queue_exempt(SLOT_W'(s), $urandom);
    wait_idle();

    // Host limit hit, exempt host let through, busy at the total, expiry sweep.
    apply_settings(16'd10, 8'd3, 8'd1, 4'd2);
    queue_connect(32'd100, 32'hC0A8_0001);
    queue_connect(32'd101, 32'hC0A8_0001);
    queue_connect(32'd102, 32'h0A00_0001);
    queue_connect(32'd103, 32'h0A00_0001);
    queue_connect(32'd104, 32'hC0A8_0002);
    queue_connect(32'd200, 32'hC0A8_0001);
    queue_connect(32'd200, 32'h0000_0000);
    wait_idle();

    // Largest window with wrapping expiry, exempt count clamped to the table.
    apply_settings(16'hFFFF, 8'd128, 8'd2, 4'd15);
    queue_connect(32'hFFFF_FFFF, 32'h1234_5678);
    queue_connect(32'hFFFF_FFFF, 32'h1234_5678);
    queue_connect(32'd0, 32'h1234_5678);
    queue_connect(32'd0, 32'h1234_5678);
    queue_connect(32'd0, 32'hFFFF_FFFF);
    wait_idle();

    // Total limit of zero: busy whatever the ring holds.
    apply_settings(16'd5, 8'd0, 8'd0, 4'd0);
    queue_connect(32'd0, 32'h1234_5678);
    queue_connect(32'd1, 32'h8000_0000);
    wait_idle();

    clock_now = $urandom;
    for (int round_no = 0; round_no < ROUNDS; round_no++) begin
      if (round_no < 4) begin
        sender_idle_pct = 30;
        receiver_idle_pct = 86;
      end else if (round_no < 8) begin
        sender_idle_pct = 86;
        receiver_idle_pct = 30;
      end else begin
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
      end

      if (round_no == 0) begin
        // longest window, host limit never reached: the ring fills unless a time jump expires it
        win = 16'hFFFF; tot = 8'd128; hst = 8'd128; exc = 4'd15;
      end else if (round_no == 1) begin
        win = 16'd1; tot = 8'd1; hst = 8'd0; exc = 4'd0;
      end else begin
        case ($urandom_range(9))
          0:       win = 16'd0;
          1:       win = 16'hFFFF;
          2, 3:    win = 16'($urandom_range(1, 4));
          default: win = 16'($urandom_range(1, 200));
        endcase
        case ($urandom_range(5))
          0:       tot = 8'd128;
          1:       tot = 8'd0;
          2:       tot = 8'd1;
          default: tot = 8'($urandom_range(2, 128));
        endcase
        case ($urandom_range(5))
          0:       hst = 8'd128;
          1:       hst = 8'd0;
          2:       hst = 8'd1;
          default: hst = 8'($urandom_range(1, 6));
        endcase
        exc = 4'($urandom_range(15));
      end
      apply_settings(win, tot, hst, exc);

      if (round_no == 0) step_max = 1;
      else if ($urandom_range(1)) step_max = win / 16 + 1;
      else step_max = win / 4 + 1;
      for (int p = 0; p < 4; p++) host_pool[p] = $urandom;
      n_items = (round_no == 0) ? 200 : 80;

      if (round_no == 8) hold_requests++;

      for (int i = 0; i < n_items; i++) begin
        pick = $urandom_range(99);
        if (pick < 5) begin
          addr = (pick < 2) ? $urandom : host_pool[$urandom_range(3)];
          queue_exempt(SLOT_W'($urandom_range(EXEMPT_SLOTS - 1)), addr);
        end else begin
          if ($urandom_range(99) < 4) clock_now = clock_now + $urandom;
          else clock_now = clock_now + $urandom_range(0, step_max);
          pick = $urandom_range(99);
          if (pick < 80) addr = host_pool[$urandom_range(3)];
          else if (pick < 92) addr = exempt_tbl[$urandom_range(EXEMPT_SLOTS - 1)];
          else addr = $urandom;
          queue_connect(clock_now, addr);
        end
      end
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (ruling_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", ruling_q.size()));

    $display("Sent %0d words (%0d connects) over %0d limiter settings; checked %0d results",
             words_sent, connects_sent, ROUNDS + 4, results_checked);
    $display("Predicted verdicts: accepted or written %0d, busy %0d, host over limit %0d",
             ok_count, busy_count, host_count);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
